// ----- rtl/core/lnos_pkg.sv -----
// Shared types and constants for the Bresenham line-of-sight block.
// No dependencies; imported by the walker and the top level.
package lnos_pkg;

    localparam int unsigned GRID_BITS_DEFAULT = 8;
    localparam int unsigned COORD_W           = 8;
    // Decision term spans roughly +/- 2 * max distance
    localparam int unsigned FRAC_W            = COORD_W + 3;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic signed [FRAC_W-1:0] frac_t;

    typedef struct packed {
        logic   command;
        coord_t start_x;
        coord_t start_z;
        coord_t end_x;
        coord_t end_z;
        logic   cell_open;
    } lnos_item_t;

    typedef struct packed {
        logic   was_query;
        logic   line_clear;
        coord_t blocked_x;
        coord_t blocked_z;
    } lnos_result_t;

    // True when both coordinates fall inside a grid of 2^grid_bits per side
    function automatic logic cell_in_grid(coord_t x, coord_t z, int unsigned grid_bits);
        logic ok;
        ok = ((32'(x) >> grid_bits) == 32'd0) && ((32'(z) >> grid_bits) == 32'd0);
        return ok;
    endfunction

endpackage

// ----- rtl/core/lnos_grid_mem.sv -----
// Single-port one-bit passability grid with a registered synchronous read.
// No package dependencies.
module lnos_grid_mem #(
    parameter int unsigned ADDR_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic              wr_data,
    output logic              rd_data
);

    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic grid_mem [0:DEPTH-1];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= grid_mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/lnos_walker.sv -----
// Item sequencer: grid writes and the Bresenham walk, at most one memory read per step.
// Uses lnos_pkg; drives the port of lnos_grid_mem.
module lnos_walker #(
    parameter int unsigned GRID_BITS = lnos_pkg::GRID_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  lnos_pkg::lnos_item_t       in_item,
    output logic                       res_valid,
    input  logic                       res_ready,
    output lnos_pkg::lnos_result_t     res,
    output logic                       mem_wr_en,
    output logic                       mem_rd_en,
    output logic [2*GRID_BITS-1:0]     mem_addr,
    output logic                       mem_wr_data,
    input  logic                       mem_rd_data
);

    import lnos_pkg::*;

    localparam int unsigned ADDR_W = 2 * GRID_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t       state_reg, state_next;
    lnos_result_t res_reg, res_next;
    logic         pend_valid_reg, pend_valid_next;

    // walk datapath
    logic   z_major_reg;
    logic   maj_dn_reg, min_dn_reg;
    coord_t maj_cur_reg, maj_end_reg, min_cur_reg;
    frac_t  frac_reg, inc_step_reg, inc_flat_reg;
    coord_t pend_x_reg, pend_z_reg;
    logic   pend_in_reg;

    logic   load, advance;

    // setup terms from the incoming item
    logic signed [COORD_W:0] dx, dz;
    coord_t adx, adz, dmaj, dmin;
    logic   z_major_in;

    // next cell along the line
    coord_t maj_nxt, min_nxt, step_x, step_z;
    frac_t  frac_nxt;
    logic   step_in, blocked_hit;

    function automatic logic [ADDR_W-1:0] cell_addr(coord_t x, coord_t z);
        return ADDR_W'((32'(z) << GRID_BITS) | 32'(x));
    endfunction

    always_comb
    begin
        dx = $signed({1'b0, in_item.end_x}) - $signed({1'b0, in_item.start_x});
        dz = $signed({1'b0, in_item.end_z}) - $signed({1'b0, in_item.start_z});
        adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        adz = dz[COORD_W] ? COORD_W'(-dz) : dz[COORD_W-1:0];
        z_major_in = adz > adx;
        dmaj = z_major_in ? adz : adx;
        dmin = z_major_in ? adx : adz;
    end

    always_comb
    begin
        maj_nxt = maj_dn_reg ? maj_cur_reg - COORD_W'(1) : maj_cur_reg + COORD_W'(1);
        if (!frac_reg[FRAC_W-1])
        begin
            min_nxt  = min_dn_reg ? min_cur_reg - COORD_W'(1) : min_cur_reg + COORD_W'(1);
            frac_nxt = frac_reg + inc_step_reg;
        end
        else
        begin
            min_nxt  = min_cur_reg;
            frac_nxt = frac_reg + inc_flat_reg;
        end
        step_x  = z_major_reg ? min_nxt : maj_nxt;
        step_z  = z_major_reg ? maj_nxt : min_nxt;
        step_in = cell_in_grid(step_x, step_z, GRID_BITS);
        // an off-grid cell or a zero read ends the walk
        blocked_hit = pend_valid_reg && !(pend_in_reg && mem_rd_data);
    end

    always_comb
    begin
        state_next      = state_reg;
        res_next        = res_reg;
        pend_valid_next = pend_valid_reg;
        load            = 1'b0;
        advance         = 1'b0;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        mem_addr        = cell_addr(in_item.start_x, in_item.start_z);
        mem_wr_data     = in_item.cell_open;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.command == CMD_WRITE)
                    begin
                        mem_wr_en  = cell_in_grid(in_item.start_x, in_item.start_z, GRID_BITS);
                        res_next   = '{was_query: 1'b0, line_clear: 1'b0,
                                       blocked_x: '0, blocked_z: '0};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        load            = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (blocked_hit)
                begin
                    res_next        = '{was_query: 1'b1, line_clear: 1'b0,
                                        blocked_x: pend_x_reg, blocked_z: pend_z_reg};
                    pend_valid_next = 1'b0;
                    state_next      = ST_DONE;
                end
                else if (maj_cur_reg == maj_end_reg)
                begin
                    res_next        = '{was_query: 1'b1, line_clear: 1'b1,
                                        blocked_x: '0, blocked_z: '0};
                    pend_valid_next = 1'b0;
                    state_next      = ST_DONE;
                end
                else
                begin
                    advance         = 1'b1;
                    mem_rd_en       = step_in;
                    mem_addr        = cell_addr(step_x, step_z);
                    pend_valid_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            res_reg        <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            z_major_reg  <= z_major_in;
            maj_dn_reg   <= z_major_in ? dz[COORD_W] : dx[COORD_W];
            min_dn_reg   <= z_major_in ? dx[COORD_W] : dz[COORD_W];
            maj_cur_reg  <= z_major_in ? in_item.start_z : in_item.start_x;
            maj_end_reg  <= z_major_in ? in_item.end_z : in_item.end_x;
            min_cur_reg  <= z_major_in ? in_item.start_x : in_item.start_z;
            frac_reg     <= $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
            inc_step_reg <= $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
            inc_flat_reg <= $signed({2'b00, dmin, 1'b0});
        end
        else if (advance)
        begin
            maj_cur_reg <= maj_nxt;
            min_cur_reg <= min_nxt;
            frac_reg    <= frac_nxt;
            pend_x_reg  <= step_x;
            pend_z_reg  <= step_z;
            pend_in_reg <= step_in;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

// ----- rtl/core/bresenham_line_of_sight_top.sv -----
// Line-of-sight top level: stream ports, output register, walker and grid memory.
// Uses lnos_pkg, lnos_walker and lnos_grid_mem.
//
// Items arrive one at a time. A write item (tuser = 0) stores one passability bit and
// is acknowledged with a result of its own. A query item (tuser = 1) walks the
// Bresenham line from start to end, reading one grid cell per cycle from the single-port
// grid memory; a blocked cell stops the walk early, and equal endpoints answer without
// reading the grid. A result waits in the output register while the next item is taken.
// The grid holds no reset value: every cell a query visits must have been written first.
module bresenham_line_of_sight_top #(
    parameter int unsigned GRID_BITS = lnos_pkg::GRID_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // start_x, start_z, end_x, end_z, cell_open, zero pad
    input  logic [lnos_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // line_clear, blocked_x, blocked_z, zero pad
    output logic [lnos_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // was_query
    output logic                            m_axis_tuser
);

    import lnos_pkg::*;

    localparam int unsigned ADDR_W = 2 * GRID_BITS;

    lnos_item_t   in_item;
    lnos_result_t res;
    logic         res_valid, res_ready;
    logic         out_valid_reg;
    lnos_result_t out_res_reg;

    logic              mem_wr_en, mem_rd_en, mem_wr_data, mem_rd_data;
    logic [ADDR_W-1:0] mem_addr;

    always_comb
    begin
        in_item.command   = s_axis_tuser;
        in_item.start_x   = s_axis_tdata[7:0];
        in_item.start_z   = s_axis_tdata[15:8];
        in_item.end_x     = s_axis_tdata[23:16];
        in_item.end_z     = s_axis_tdata[31:24];
        in_item.cell_open = s_axis_tdata[32];
    end

    assign res_ready = !out_valid_reg || m_axis_tready;

    lnos_walker #(
        .GRID_BITS (GRID_BITS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_item     (in_item),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_rd_en   (mem_rd_en),
        .mem_addr    (mem_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data)
    );

    lnos_grid_mem #(
        .ADDR_W (ADDR_W)
    ) u_grid_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.was_query;
    assign m_axis_tdata  = {7'd0, out_res_reg.blocked_z, out_res_reg.blocked_x,
                            out_res_reg.line_clear};

endmodule

// ----- tb/sight_line_checker.sv -----
// Scoreboard for the line-of-sight block: watches both stream channels,
// keeps its own copy of the passability grid and traces each query line.
// Depends on lnos_pkg for field widths, command codes and the result struct.
module sight_line_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [lnos_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [lnos_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             m_tuser,
    output int                               errors,
    output int                               pending,
    output int                               answers
);
    timeunit 1ns;
    timeprecision 1ps;

    import lnos_pkg::*;

    bit open_map [0:65535];
    lnos_result_t answer_q [$];
    int err_count = 0;
    int n_answers = 0;

    // Bresenham walk from start to end; the start cell is never looked at
    function automatic lnos_result_t trace_line(coord_t sx, coord_t sz, coord_t ex, coord_t ez);
        lnos_result_t res;
        int dx, dz, stx, stz, cx, cz, frac;
        bit hit;
        res = '0;
        res.was_query = 1'b1;
        hit = 1'b0;
        dx = int'(ex) - int'(sx);
        dz = int'(ez) - int'(sz);
        stx = (dx < 0) ? -1 : 1;
        stz = (dz < 0) ? -1 : 1;
        if (dx < 0) dx = -dx;
        if (dz < 0) dz = -dz;
        cx = sx;
        cz = sz;
        if (dz > dx)
        begin
            frac = 2 * dx - dz;
            while (cz != int'(ez))
            begin
                if (frac >= 0)
                begin
                    cx += stx;
                    frac += 2 * dx - 2 * dz;
                end
                else
                    frac += 2 * dx;
                cz += stz;
                if (!open_map[{cz[7:0], cx[7:0]}])
                begin
                    hit = 1'b1;
                    break;
                end
            end
        end
        else
        begin
            frac = 2 * dz - dx;
            while (cx != int'(ex))
            begin
                if (frac >= 0)
                begin
                    cz += stz;
                    frac += 2 * dz - 2 * dx;
                end
                else
                    frac += 2 * dz;
                cx += stx;
                if (!open_map[{cz[7:0], cx[7:0]}])
                begin
                    hit = 1'b1;
                    break;
                end
            end
        end
        if (hit)
        begin
            res.blocked_x = cx[7:0];
            res.blocked_z = cz[7:0];
        end
        else
            res.line_clear = 1'b1;
        return res;
    endfunction

    task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        lnos_result_t want;
        lnos_result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_WRITE)
                begin
                    open_map[{s_tdata[15:8], s_tdata[7:0]}] = s_tdata[32];
                    want = '0;
                end
                else
                    want = trace_line(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                                      s_tdata[31:24]);
                answer_q = {answer_q, want};
            end
            if (m_tvalid && m_tready)
            begin
                got.was_query  = m_tuser;
                got.line_clear = m_tdata[0];
                got.blocked_x  = m_tdata[8:1];
                got.blocked_z  = m_tdata[16:9];
                n_answers++;
                if (answer_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %p", $time, got);
                    err_count++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    check_field("was_query", want.was_query, got.was_query);
                    check_field("line_clear", want.line_clear, got.line_clear);
                    check_field("blocked_x", want.blocked_x, got.blocked_x);
                    check_field("blocked_z", want.blocked_z, got.blocked_z);
                    check_field("tdata pad", 16'd0, m_tdata[M_TDATA_W-1:17]);
                end
            end
        end
        errors  <= err_count;
        pending <= answer_q.size();
        answers <= n_answers;
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for bresenham_line_of_sight_top: clock, reset, item stimulus,
// output back-pressure and verdict. Checking lives in sight_line_checker.
// Depends on lnos_pkg and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lnos_pkg::*;

    localparam int RANDOM_ITEMS = 120;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int LOW_BASE     = 0;
    localparam int HIGH_BASE    = 248;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int errors, pending, answers;
    int tx_idle_pct = 24;
    int rx_idle_pct = 87;
    int phase = 1;
    int n_writes = 0;
    int n_queries = 0;
    int cycles = 0;

    bresenham_line_of_sight_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    sight_line_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending),
        .answers  (answers)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Output back-pressure; one long hold once the no-idle phase starts
    initial
    begin
        int held;
        bit hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (phase == 3 && !hold_done)
            begin
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(logic cmd, coord_t sx, coord_t sz, coord_t ex, coord_t ez,
                             logic cell_open);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, cell_open, ez, ex, sz, sx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd == CMD_QUERY)
            n_queries++;
        else
            n_writes++;
    endtask

    // end fields are don't-care for writes, so they get noise
    task automatic write_cell(coord_t x, coord_t z, logic cell_open);
        send_item(CMD_WRITE, x, z, coord_t'($urandom), coord_t'($urandom), cell_open);
    endtask

    task automatic query_line(coord_t sx, coord_t sz, coord_t ex, coord_t ez);
        send_item(CMD_QUERY, sx, sz, ex, ez, logic'($urandom_range(1)));
    endtask

    function automatic coord_t window_coord(int base);
        return coord_t'(base + $urandom_range(7));
    endfunction

    initial
    begin
        int i, x, z, r, base;
        coord_t sx, sz, ex, ez;
        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_WRITE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Preload: two 8x8 corner windows, row z=0 and the lower half of
        // column x=255. Queries only ever run inside these.
        for (z = 0; z < 8; z++)
            for (x = 0; x < 8; x++)
            begin
                write_cell(coord_t'(LOW_BASE + x), coord_t'(LOW_BASE + z),
                           $urandom_range(3) != 0);
                write_cell(coord_t'(HIGH_BASE + x), coord_t'(HIGH_BASE + z),
                           $urandom_range(3) != 0);
            end
        for (x = 0; x < 256; x++)
            write_cell(coord_t'(x), 8'd0, 1'b1);
        for (z = 0; z < 128; z++)
            write_cell(8'd255, coord_t'(z), $urandom_range(31) != 0);

        // Directed: equal endpoints, long walks, blocked start cell,
        // first blocked cell, every octant and the dx == dz tie
        query_line(8'd0, 8'd0, 8'd0, 8'd0);
        query_line(8'd255, 8'd255, 8'd255, 8'd255);
        query_line(8'd0, 8'd0, 8'd255, 8'd0);
        query_line(8'd255, 8'd0, 8'd0, 8'd0);
        query_line(8'd255, 8'd0, 8'd255, 8'd127);
        query_line(8'd255, 8'd127, 8'd255, 8'd0);
        write_cell(8'd0, 8'd0, 1'b0);
        query_line(8'd0, 8'd0, 8'd15, 8'd0);
        write_cell(8'd2, 8'd0, 1'b0);
        query_line(8'd0, 8'd0, 8'd5, 8'd0);
        write_cell(8'd0, 8'd0, 1'b1);
        write_cell(8'd2, 8'd0, 1'b1);
        query_line(8'd4, 8'd4, 8'd7, 8'd6);
        query_line(8'd4, 8'd4, 8'd6, 8'd7);
        query_line(8'd4, 8'd4, 8'd2, 8'd7);
        query_line(8'd4, 8'd4, 8'd0, 8'd6);
        query_line(8'd4, 8'd4, 8'd0, 8'd2);
        query_line(8'd4, 8'd4, 8'd2, 8'd0);
        query_line(8'd4, 8'd4, 8'd6, 8'd0);
        query_line(8'd4, 8'd4, 8'd7, 8'd2);
        query_line(8'd4, 8'd4, 8'd7, 8'd7);
        query_line(8'd4, 8'd4, 8'd0, 8'd0);
        query_line(8'd248, 8'd255, 8'd255, 8'd248);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                phase = 2;
                tx_idle_pct = 87;
                rx_idle_pct = 24;
            end
            else if (i == 2 * RANDOM_ITEMS / 3)
            begin
                phase = 3;
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            r = $urandom_range(99);
            base = $urandom_range(1) ? HIGH_BASE : LOW_BASE;
            if (r < 15)
                write_cell(coord_t'($urandom), coord_t'($urandom), logic'($urandom_range(1)));
            else if (r < 30)
                write_cell(window_coord(base), window_coord(base), $urandom_range(3) != 0);
            else if (r < 38)
            begin
                if ($urandom_range(1))
                    write_cell(coord_t'($urandom), 8'd0, $urandom_range(7) != 0);
                else
                    write_cell(8'd255, coord_t'($urandom), $urandom_range(7) != 0);
            end
            else if (r < 75)
            begin
                sx = window_coord(base);
                sz = window_coord(base);
                if ($urandom_range(9) == 0)
                begin
                    ex = sx;
                    ez = sz;
                end
                else
                begin
                    ex = window_coord(base);
                    ez = window_coord(base);
                end
                query_line(sx, sz, ex, ez);
            end
            else if (r < 90)
                query_line(coord_t'($urandom), 8'd0, coord_t'($urandom), 8'd0);
            else
                query_line(8'd255, coord_t'($urandom_range(127)), 8'd255,
                           coord_t'($urandom_range(127)));
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d cell writes and %0d line queries over corner windows,",
                 n_writes, n_queries);
        $display("a full row, half a column, three pacing modes and one long output stall; %0d answers compared.",
                 answers);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
